// ===== rtl/core/msfd_pkg.sv =====
// Shared types and constants for the magic-sync frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package msfd_pkg;

    // Header layout
    localparam int HEADER_BYTES = 10;
    localparam int WIN_BYTES    = HEADER_BYTES - 1;
    localparam int POS_VERSION  = 4;
    localparam int POS_TYPE     = 5;
    localparam int POS_LENGTH   = 6;
    localparam int FILL_W       = $clog2(HEADER_BYTES);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_MAGIC       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 2'd1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EMPTY   = 1'b1;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] msg_type;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Front status, watched by the top level
    typedef struct packed {
        logic              in_payload;
        logic [FILL_W-1:0] fill;
    } t_front_stat;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage
`default_nettype wire

// ===== rtl/core/msfd_front.sv =====
// Front end: header window, magic/version check and payload tagging.
// Depends on msfd_pkg; produces at most one result per accepted byte.
`default_nettype none
module msfd_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic [31:0]           i_sync_magic,
    input  wire logic [7:0]            i_expected_version,
    output logic                       o_res_valid,
    output msfd_pkg::t_result          o_result,
    output msfd_pkg::t_front_stat      o_stat
);
    import msfd_pkg::*;

    logic [7:0]        r_window [WIN_BYTES];
    logic [7:0]        n_window [WIN_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_in_payload, n_in_payload;
    logic [31:0]       r_rem, n_rem;
    logic [7:0]        r_held_type, n_held_type;

    logic [31:0] hdr_magic;
    logic [31:0] hdr_length;
    logic        hdr_ok;
    logic [31:0] rem_dec;

    // Parallel header check on the stored bytes plus the incoming one
    assign hdr_magic  = {r_window[0], r_window[1], r_window[2], r_window[3]};
    assign hdr_length = {r_window[POS_LENGTH], r_window[POS_LENGTH+1],
                         r_window[POS_LENGTH+2], i_rx_byte};
    assign hdr_ok     = (hdr_magic == i_sync_magic) &&
                        (r_window[POS_VERSION] == i_expected_version);
    assign rem_dec    = (r_rem != 32'd0) ? (r_rem - 32'd1) : 32'd0;

    // Classify the byte and compute next state
    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_rem        = r_rem;
        n_held_type  = r_held_type;
        o_res_valid  = 1'b0;
        o_result     = '{kind: KIND_PAYLOAD, msg_type: r_held_type, data: i_rx_byte,
                         last: (r_rem[31:1] == 31'd0)};
        if (i_accept) begin
            if (r_in_payload) begin
                // Pass payload byte through
                o_res_valid = 1'b1;
                n_rem       = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_in_payload = 1'b0;
                    n_fill       = '0;
                end
            end else if (r_fill != FILL_W'(WIN_BYTES)) begin
                // Append header byte
                n_window[r_fill] = i_rx_byte;
                n_fill           = r_fill + 1'b1;
            end else if (!hdr_ok) begin
                // Drop the oldest byte and keep hunting
                for (int i = 0; i < WIN_BYTES - 1; i++) begin
                    n_window[i] = r_window[i+1];
                end
                n_window[WIN_BYTES-1] = i_rx_byte;
            end else begin
                // Header accepted
                n_held_type = r_window[POS_TYPE];
                n_fill      = '0;
                if (hdr_length == 32'd0) begin
                    o_res_valid = 1'b1;
                    o_result    = '{kind: KIND_EMPTY, msg_type: r_window[POS_TYPE],
                                    data: 8'd0, last: 1'b1};
                end else begin
                    n_in_payload = 1'b1;
                    n_rem        = hdr_length;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_rem        <= 32'd0;
            r_held_type  <= 8'd0;
        end else begin
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_rem        <= n_rem;
            r_held_type  <= n_held_type;
        end
    end

    // Header bytes
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    assign o_stat = '{in_payload: r_in_payload, fill: r_fill};

endmodule
`default_nettype wire

// ===== rtl/core/msfd_queue.sv =====
// Short result queue between the front end and the result ports.
// Depends on msfd_pkg for the result record type.
`default_nettype none
module msfd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  msfd_pkg::t_result         i_wdata,
    input  wire logic                 i_rd,
    output msfd_pkg::t_result         o_rdata,
    output msfd_pkg::t_queue_stat     o_stat
);
    import msfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_wr, do_rd;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_wr = i_wr && !o_stat.full;
    assign do_rd = i_rd && !o_stat.empty;

    // Store request
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/magic_sync_frame_deframer.sv =====
// Top level of the magic-sync frame deframer: config registers, front end, queue.
// Depends on msfd_pkg, msfd_front and msfd_queue.
`default_nettype none
// The deframer takes one stream byte per clock cycle whenever full is low. It
// hunts for a 10-byte header (big-endian magic, version, type, big-endian
// length), sliding one byte at a time until magic and version match, then
// tags each payload byte with the header type and flags the last one; a
// zero-length frame gives a single empty-message result. Every byte is
// classified in the cycle it is accepted, and any result is written into a
// FIFO_DEPTH-entry queue, so a result appears on the output side in the cycle
// after its byte. full rises only when that queue holds FIFO_DEPTH results
// not yet popped; the queue alone sets the throughput, one byte per cycle
// while results are drained. Write configuration only while idle.
module magic_sync_frame_deframer #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input side
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       i_rx_byte,
    // Result side
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  o_result_kind,
    output logic [7:0]                            o_message_type,
    output logic [7:0]                            o_payload_byte,
    output logic                                  o_last_of_message,
    // Configuration
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [msfd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                      i_cfg_wdata
);
    import msfd_pkg::*;

    logic [31:0]  r_sync_magic;
    logic [7:0]   r_expected_version;
    logic         accept;
    logic         res_valid;
    t_result      front_res;
    t_result      queue_res;
    t_front_stat  front_stat;
    t_queue_stat  queue_stat;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_magic       <= 32'd0;
            r_expected_version <= 8'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SYNC_MAGIC:       r_sync_magic       <= i_cfg_wdata;
                REG_EXPECTED_VERSION: r_expected_version <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign full   = queue_stat.full;
    assign empty  = queue_stat.empty;
    assign accept = push && !queue_stat.full;

    msfd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_rx_byte          (i_rx_byte),
        .i_sync_magic       (r_sync_magic),
        .i_expected_version (r_expected_version),
        .o_res_valid        (res_valid),
        .o_result           (front_res),
        .o_stat             (front_stat)
    );

    msfd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (front_res),
        .i_rd    (pop),
        .o_rdata (queue_res),
        .o_stat  (queue_stat)
    );

    assign o_result_kind     = queue_res.kind;
    assign o_message_type    = queue_res.msg_type;
    assign o_payload_byte    = queue_res.data;
    assign o_last_of_message = queue_res.last;

    // A result written into the queue is visible next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> !empty)
        else $error("result written but queue empty");

    // Last payload byte returns the front end to header hunting
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && front_res.last) |=>
            (!front_stat.in_payload && front_stat.fill == '0))
        else $error("front end did not restart after last byte");

    // Payload mode never holds header bytes, and the window never overfills
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_stat.fill <= FILL_W'(WIN_BYTES)) &&
        (!front_stat.in_payload || front_stat.fill == '0))
        else $error("header fill out of range");

endmodule
`default_nettype wire

// ===== sim/magic_sync_frame_deframer_tb.sv =====
// Self-checking testbench for magic_sync_frame_deframer: byte requests in, tagged payload out.
// Depends on msfd_pkg and the deframer RTL; carries its own deframing predictor.
`default_nettype none
module magic_sync_frame_deframer_tb;
    import msfd_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 11;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int RANDOM_BYTES     = 36;
    localparam int TIMEOUT          = 4_000_000;

    // Indexes outside the register map; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             i_rx_byte = 8'h00;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   o_result_kind;
    logic [7:0]             o_message_type;
    logic [7:0]             o_payload_byte;
    logic                   o_last_of_message;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [31:0]            i_cfg_wdata = '0;

    // Stream bytes waiting to be offered, and results the deframer still owes
    logic [7:0] stream_q [$];
    t_result    due_results [$];
    int         bytes_queued = 0;
    int         fail_count = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    logic       hold_go = 1'b0;
    logic       rx_hold = 1'b0;

    // Predictor state and its copy of the registers
    logic [31:0] want_magic = 32'h0000_0000;
    logic [7:0]  want_version = 8'h01;
    logic [7:0]  hdr_win [HEADER_BYTES];
    int          hdr_fill = 0;
    logic        in_body = 1'b0;
    logic [31:0] body_left = 32'h0;
    logic [7:0]  body_type = 8'h00;

    magic_sync_frame_deframer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (i_rx_byte),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_message_type    (o_message_type),
        .o_payload_byte    (o_payload_byte),
        .o_last_of_message (o_last_of_message),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Append one byte to the pending stream
    function automatic void put_stream_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endfunction

    // Append one predicted result to the owed list
    function automatic void owe_result(input t_result r);
        due_results = {due_results, r};
    endfunction

    // Clear the header window and return to header hunting
    function automatic void clear_window();
        for (int i = 0; i < HEADER_BYTES; i++) hdr_win[i] = 8'h00;
        hdr_fill = 0;
        in_body = 1'b0;
    endfunction

    // Advance the predictor by one stream byte; queue any result it yields
    function automatic void deframe_byte(input logic [7:0] b);
        t_result     res;
        logic [31:0] magic_seen;
        if (in_body) begin
            res.kind     = KIND_PAYLOAD;
            res.msg_type = body_type;
            res.data     = b;
            res.last     = (body_left <= 32'd1);
            owe_result(res);
            if (body_left != 32'd0) body_left = body_left - 32'd1;
            if (body_left == 32'd0) clear_window();
            return;
        end
        if (hdr_fill >= HEADER_BYTES) hdr_fill = HEADER_BYTES - 1;
        hdr_win[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill < HEADER_BYTES) return;
        magic_seen = {hdr_win[0], hdr_win[1], hdr_win[2], hdr_win[3]};
        // Slide by one byte on a magic or version mismatch
        if (magic_seen != want_magic || hdr_win[POS_VERSION] != want_version) begin
            for (int i = 0; i < HEADER_BYTES - 1; i++) hdr_win[i] = hdr_win[i + 1];
            hdr_win[HEADER_BYTES - 1] = 8'h00;
            hdr_fill = HEADER_BYTES - 1;
            return;
        end
        body_type = hdr_win[POS_TYPE];
        body_left = {hdr_win[POS_LENGTH], hdr_win[POS_LENGTH + 1],
                     hdr_win[POS_LENGTH + 2], hdr_win[POS_LENGTH + 3]};
        clear_window();
        if (body_left == 32'd0) begin
            res.kind     = KIND_EMPTY;
            res.msg_type = body_type;
            res.data     = 8'h00;
            res.last     = 1'b1;
            owe_result(res);
            return;
        end
        in_body = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sender: offer the oldest pending byte unless idling this cycle
    always @(negedge i_clk) begin
        if (i_rst_n && stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            push      <= 1'b1;
            i_rx_byte <= stream_q[0];
        end else begin
            push <= 1'b0;
        end
    end

    // Receiver: pop at random, nothing while the long hold is on
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Hold off the receiver once for a long stretch so the result queue fills
    initial begin : long_hold
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Check popped results, then predict from the accepted request
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d type %0d data %0d last %0d",
                           o_result_kind, o_message_type, o_payload_byte, o_last_of_message);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("message_type", want.msg_type, o_message_type);
                    check_field("payload_byte", want.data, o_payload_byte);
                    check_field("last_of_message", want.last, o_last_of_message);
                end
            end
            if (push && !full) begin
                deframe_byte(i_rx_byte);
                stream_q.delete(0);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_SYNC_MAGIC) want_magic = data;
        else if (idx == REG_EXPECTED_VERSION) want_version = data[7:0];
    endtask

    // Queue the first n_hdr bytes of a header
    task automatic add_header(input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] mtype, input int len, input int n_hdr);
        logic [79:0] hdr;
        hdr = {magic, ver, mtype, 32'(len)};
        for (int i = 0; i < n_hdr; i++) put_stream_byte(hdr[79 - 8 * i -: 8]);
        bytes_queued += n_hdr;
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++) put_stream_byte(8'($urandom_range(255)));
        bytes_queued += n;
    endtask

    task automatic add_good_frame(input int len);
        add_header(want_magic, want_version, 8'($urandom_range(255)), len, HEADER_BYTES);
        add_random_bytes(len);
    endtask

    // Mostly short payloads, with empty and single-byte messages weighted up
    function automatic int frame_length();
        case ($urandom_range(9))
            0, 1:    return 0;
            2, 3:    return 1;
            9:       return $urandom_range(40, 13);
            default: return $urandom_range(12, 2);
        endcase
    endfunction

    // Wait until every request is taken and every result has come back
    task automatic wait_drained();
        while (stream_q.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pick a magic of four distinct non-trivial bytes and a version unlike any of them,
    // so broken or cut headers cannot line up into a false header
    task automatic pick_config();
        logic [31:0] m;
        logic [7:0]  b;
        logic [7:0]  v;
        m = 32'h0;
        for (int i = 0; i < 4; i++) begin
            do b = 8'($urandom_range(254, 1));
            while (b == m[7:0] || b == m[15:8] || b == m[23:16] || b == m[31:24]);
            m[8 * i +: 8] = b;
        end
        do v = 8'($urandom_range(255));
        while (v == m[7:0] || v == m[15:8] || v == m[23:16] || v == m[31:24]);
        write_reg(REG_SYNC_MAGIC, m);
        write_reg(REG_EXPECTED_VERSION, {24'($urandom), v});
    endtask

    task automatic add_random_traffic(input int n_bytes);
        int target;
        int pick;
        int len;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            pick = $urandom_range(99);
            len  = frame_length();
            if (pick < 76) begin
                add_good_frame(len);
            end else if (pick < 82) begin
                // one magic bit flipped
                add_header(want_magic ^ (32'd1 << $urandom_range(31)), want_version,
                           8'($urandom_range(255)), len, HEADER_BYTES);
                add_random_bytes(len);
            end else if (pick < 88) begin
                add_header(want_magic, want_version ^ 8'($urandom_range(255, 1)),
                           8'($urandom_range(255)), len, HEADER_BYTES);
                add_random_bytes(len);
            end else if (pick < 93) begin
                // header cut off after one to four magic bytes
                add_header(want_magic, want_version, 8'h00, 0, $urandom_range(4, 1));
            end else begin
                add_random_bytes($urandom_range(12, 1));
            end
        end
        add_good_frame(frame_length());
    endtask

    initial begin : stimulus
        int tx_pcts [4];
        int rx_pcts [4];
        tx_pcts = '{0, 64, 0, 23};
        rx_pcts = '{0, 0, 64, 23};
        clear_window();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: empty message and extreme payload bytes
        add_header(32'h0, 8'h01, 8'h00, 0, HEADER_BYTES);
        add_header(32'h0, 8'h01, 8'hFF, 1, HEADER_BYTES);
        put_stream_byte(8'hFF);
        add_header(32'h0, 8'h01, 8'h5A, 2, HEADER_BYTES);
        put_stream_byte(8'h00);
        put_stream_byte(8'h81);
        bytes_queued += 3;
        wait_drained();

        // Resync cases; unmapped register writes must change nothing
        pick_config();
        write_reg(REG_UNMAPPED_LO, $urandom);
        write_reg(REG_UNMAPPED_HI, $urandom);
        add_header(want_magic ^ 32'h0000_0100, want_version, 8'h11, 1, HEADER_BYTES);
        add_random_bytes(1);
        add_good_frame(2);
        add_header(want_magic, want_version ^ 8'h80, 8'h22, 3, HEADER_BYTES);
        add_good_frame(0);
        add_header(want_magic, want_version, 8'h00, 0, 4);
        add_good_frame(1);
        add_random_bytes(3);
        add_good_frame(3);
        wait_drained();

        // Register extremes
        write_reg(REG_SYNC_MAGIC, 32'hFFFF_FFFF);
        write_reg(REG_EXPECTED_VERSION, {24'($urandom), 8'hFF});
        add_good_frame(0);
        add_good_frame(2);
        wait_drained();
        write_reg(REG_SYNC_MAGIC, 32'h0000_0000);
        write_reg(REG_EXPECTED_VERSION, 32'h0000_0000);
        add_good_frame(1);
        add_good_frame(0);
        wait_drained();

        // Long message against a stalled receiver; length spans two bytes
        pick_config();
        hold_go = 1'b1;
        add_good_frame(32'h0000_0105);
        wait_drained();

        // Random traffic under each idling mix
        for (int p = 0; p < 4; p++) begin
            pick_config();
            tx_idle_pct  = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            add_random_traffic(RANDOM_BYTES);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("magic_sync_frame_deframer test passed");
        end else begin
            $display("magic_sync_frame_deframer test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("magic_sync_frame_deframer test failed");
        $finish;
    end

endmodule
`default_nettype wire
